// File: sv/aoa_tdoa_outlier_gate_defines.svh
// Assertion macros for the AOA/TDOA outlier gate.
// Used by the top level; needs nothing else.
`ifndef AOA_TDOA_OUTLIER_GATE_DEFINES_SVH
`define AOA_TDOA_OUTLIER_GATE_DEFINES_SVH
// Same-cycle implication.
`define AOG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define AOG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: sv/aog_pkg.sv
// Package for the AOA/TDOA outlier gate: payload structs, lane control,
// register indexes and fixed-point constants. Depends on nothing.
`default_nettype none
package aog_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam logic [63:0] PI_Q32 = 64'd13493037705;
   localparam int DEG_HALF_TURN = 180;
   localparam int N_LANES = 6;
   localparam int N_ANGLES = 3;

   localparam logic [1:0] CSR_AOA_STD  = 2'd0;
   localparam logic [1:0] CSR_TDOA_STD = 2'd1;
   localparam logic [1:0] CSR_THRESH   = 2'd2;

   typedef struct packed {
      logic signed [31:0] aoa_0;
      logic signed [31:0] aoa_1;
      logic signed [31:0] aoa_2;
      logic signed [31:0] tdoa_0;
      logic signed [31:0] tdoa_1;
      logic signed [31:0] tdoa_2;
      logic [15:0]        sample_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] slot_0;
      logic signed [31:0] slot_1;
      logic signed [31:0] slot_2;
      logic signed [31:0] slot_3;
      logic signed [31:0] slot_4;
      logic signed [31:0] slot_5;
      logic [1:0]         kept_angles;
      logic [1:0]         kept_delays;
      logic [5:0]         valid_mask;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic release_lane;
   } lane_ctrl_type;

   typedef struct packed {
      logic               done;
      logic               keep;
      logic signed [31:0] value;
   } lane_stat_type;

endpackage
`default_nettype wire

// File: sv/aog_fdiv.sv
// Iterative radix-2 floor divider: signed dividend, positive divisor.
// Uses nothing from the package.
`default_nettype none
module aog_fdiv #(
   parameter int DW = 33,
   parameter int VW = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [DW-1:0] dividend,
   input  wire logic [VW-1:0]        divisor,
   output logic                      busy,
   output logic signed [DW-1:0]      quotient
);
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] q_ff, q_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dv_ff, dv_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          ge;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, q_ff[DW-1]};
      diff    = trial - {1'b0, dv_ff};
      ge      = (trial >= {1'b0, dv_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         neg_in  = dividend[DW-1];
         q_in    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
         rem_in  = '0;
         dv_in   = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[DW-2:0], ge};
         rem_in = ge ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            // floor for negative dividends: negate, step down on remainder
            quot_in = neg_ff ? (DW'(-q_in) - DW'(rem_in != '0)) : q_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      quot_ff <= quot_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

// File: sv/aog_lane.sv
// One measurement lane: running mean, z-score gate and, in angle lanes, radian conversion.
// Depends on aog_pkg and aog_fdiv.
`default_nettype none
module aog_lane import aog_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter bit IS_ANGLE  = 1'b1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lane_ctrl_type      ctrl,
   input  wire logic signed [31:0] x,
   input  wire logic [15:0]        n,
   input  wire logic [30:0]        sd,
   input  wire logic signed [31:0] thr,
   output lane_stat_type           stat
);
   typedef enum logic [5:0] {
      L_IDLE = 6'b000001,
      L_MUL  = 6'b000010,
      L_GO   = 6'b000100,
      L_DIV  = 6'b001000,
      L_MEAN = 6'b010000,
      L_CMP  = 6'b100000
   } lane_state_type;

   localparam logic [63:0] PI_Q = PI_Q32 >> (32 - FRAC_BITS);
   localparam logic signed [FRAC_BITS+2:0] PI_S = {1'b0, PI_Q[FRAC_BITS+1:0]};
   // divide by 45: bias = 45 * RAD_K, reciprocal = ceil(2^40 / 45)
   localparam logic [33:0] RAD_BIAS = 34'd4294967310;
   localparam logic [31:0] RAD_K    = 32'd95443718;
   localparam logic [34:0] RAD_M    = 35'd24433591729;

   lane_state_type     state_ff, state_in;
   logic               done_ff, done_in;
   logic               keep_ff, keep_in;
   logic signed [31:0] mean_ff, mean_in;
   logic signed [31:0] x_ff;
   logic [15:0]        n_ff;
   logic signed [65:0] rhs_ff;
   logic signed [64:0] rhs_prod;
   logic signed [32:0] thr_p1;
   logic signed [31:0] sd_s;
   logic               go;
   logic               busy_a, busy_b;
   logic signed [32:0] qa, qb;
   logic signed [31:0] rad_val;
   logic signed [34:0] sum;
   logic signed [32:0] diff;
   logic signed [65:0] lhs;

   assign thr_p1   = {thr[31], thr} + 33'sd1;
   assign sd_s     = {1'b0, (sd == '0) ? 31'd1 : sd};
   assign rhs_prod = thr_p1 * sd_s;
   assign go       = (state_ff == L_GO);
   assign sum      = {{3{mean_ff[31]}}, mean_ff} + {{2{qa[32]}}, qa} + {{2{qb[32]}}, qb};
   assign diff     = {x_ff[31], x_ff} - {mean_ff[31], mean_ff};
   assign lhs      = {{33{diff[32]}}, diff} <<< FRAC_BITS;

   aog_fdiv #(.DW(33), .VW(16)) u_div_old (
      .clock, .reset, .start(go),
      .dividend(-{mean_ff[31], mean_ff}), .divisor(n_ff),
      .busy(busy_a), .quotient(qa)
   );

   aog_fdiv #(.DW(33), .VW(16)) u_div_x (
      .clock, .reset, .start(go),
      .dividend({x_ff[31], x_ff}), .divisor(n_ff),
      .busy(busy_b), .quotient(qb)
   );

   if (IS_ANGLE) begin : g_rad
      // floor by 180: drop two bits, bias to non-negative, then divide by 45
      // with a reciprocal multiply, registered in rad_u, rad_lo/rad_hi and rad_acc
      logic signed [34+FRAC_BITS:0] rad_prod_ff;
      logic signed [32:0]           rad_q4;
      logic [33:0]                  rad_u_ff;
      logic [50:0]                  rad_lo_ff;
      logic [51:0]                  rad_hi_ff;
      logic [68:0]                  rad_acc_ff;
      assign rad_q4 = rad_prod_ff[34+FRAC_BITS:FRAC_BITS+2];
      always_ff @(posedge clock) begin
         if (state_ff == L_MUL) rad_prod_ff <= x_ff * PI_S;
         rad_u_ff   <= {rad_q4[32], rad_q4} + RAD_BIAS;
         rad_lo_ff  <= rad_u_ff * RAD_M[16:0];
         rad_hi_ff  <= rad_u_ff * RAD_M[34:17];
         rad_acc_ff <= {rad_hi_ff, 17'd0} + {18'd0, rad_lo_ff};
      end
      assign rad_val = 32'(rad_acc_ff[68:40]) - RAD_K;
   end else begin : g_raw
      assign rad_val = x_ff;
   end

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      keep_in  = keep_ff;
      mean_in  = mean_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (ctrl.release_lane) done_in = 1'b0;
            if (ctrl.start) state_in = L_MUL;
         end
         L_MUL: state_in = L_GO;
         L_GO:  state_in = L_DIV;
         L_DIV: if (!busy_a && !busy_b) state_in = L_MEAN;
         L_MEAN: begin
            if (sum > 35'sd2147483647)       mean_in = 32'sh7fffffff;
            else if (sum < -35'sd2147483648) mean_in = 32'sh80000000;
            else                             mean_in = sum[31:0];
            state_in = L_CMP;
         end
         L_CMP: begin
            // z > thr exactly when diff*2^F >= (thr+1)*sd
            keep_in  = !(lhs >= rhs_ff);
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
         mean_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         mean_ff  <= mean_in;
      end
      keep_ff <= keep_in;
      if (ctrl.start && state_ff == L_IDLE) begin
         x_ff <= x;
         n_ff <= (n == '0) ? 16'd1 : n;
      end
      if (state_ff == L_MUL) rhs_ff <= {rhs_prod[64], rhs_prod};
   end

   assign stat.done  = done_ff;
   assign stat.keep  = keep_ff;
   assign stat.value = rad_val;
endmodule
`default_nettype wire

// File: sv/aog_pack.sv
// Merge stage: packs kept lane values into slots, angles first, and counts.
// Depends on aog_pkg.
`default_nettype none
module aog_pack import aog_pkg::*; (
   input  wire logic [N_LANES-1:0]            keep,
   input  wire logic [N_LANES-1:0][31:0]      vals,
   output rsp_type                            rsp
);
   logic [N_LANES-1:0][31:0] slots;
   logic [2:0]               k;

   always_comb begin
      slots = '0;
      k     = '0;
      for (int i = 0; i < N_LANES; i++) begin
         if (keep[i]) begin
            slots[k] = vals[i];
            k        = k + 3'd1;
         end
      end
      rsp.slot_0      = slots[0];
      rsp.slot_1      = slots[1];
      rsp.slot_2      = slots[2];
      rsp.slot_3      = slots[3];
      rsp.slot_4      = slots[4];
      rsp.slot_5      = slots[5];
      rsp.kept_angles = 2'({1'b0, keep[0]} + {1'b0, keep[1]} + {1'b0, keep[2]});
      rsp.kept_delays = 2'({1'b0, keep[3]} + {1'b0, keep[4]} + {1'b0, keep[5]});
      rsp.valid_mask  = keep;
   end
endmodule
`default_nettype wire

// File: sv/aoa_tdoa_outlier_gate.sv
// Outlier gate for one vector of three angles and three TDOA values. Each
// beat updates six running means, drops every value whose z-score is above
// the threshold, converts kept angles to radians and packs the kept values
// into six slots, angles first, zero elsewhere. One lane per value works in
// parallel; the time from acceptance to result is set by the 33-step radix-2
// dividers of the running-mean update in every lane (the radian conversion
// is a short reciprocal multiply that finishes while those dividers run).
// The next beat is taken the cycle after the result enters the output
// register, even while that result still waits, so a new beat is never
// taken before the last one's result has been captured.
`default_nettype none
`include "aoa_tdoa_outlier_gate_defines.svh"
module aoa_tdoa_outlier_gate import aog_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   typedef enum logic [1:0] {
      T_IDLE = 2'b01,
      T_BUSY = 2'b10
   } top_state_type;

   top_state_type         state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               packed_rsp;
   logic [30:0]           aoa_std_ff, tdoa_std_ff;
   logic signed [31:0]    thr_ff;
   logic                  accept, capture, all_done, any_done;
   lane_ctrl_type         ctrl;
   lane_stat_type [N_LANES-1:0] stat;
   logic [N_LANES-1:0]    keep_vec, done_vec;
   logic [N_LANES-1:0][31:0] val_vec;
   logic [N_LANES-1:0][31:0] x_vec;

   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;
   assign all_done  = &done_vec;
   assign any_done  = |done_vec;
   // capture only when the output register is free or being emptied
   assign capture   = (state_ff == T_BUSY) && all_done && (!rsp_valid_ff || !rsp_stall);

   assign ctrl.start        = accept;
   assign ctrl.release_lane = capture;

   assign x_vec = {req_data.tdoa_2, req_data.tdoa_1, req_data.tdoa_0,
                   req_data.aoa_2, req_data.aoa_1, req_data.aoa_0};

   for (genvar i = 0; i < N_LANES; i++) begin : g_lane
      aog_lane #(.FRAC_BITS(FRAC_BITS), .IS_ANGLE(i < N_ANGLES)) u_lane (
         .clock, .reset, .ctrl,
         .x(x_vec[i]),
         .n(req_data.sample_count),
         .sd((i < N_ANGLES) ? aoa_std_ff : tdoa_std_ff),
         .thr(thr_ff),
         .stat(stat[i])
      );
      assign keep_vec[i] = stat[i].keep;
      assign done_vec[i] = stat[i].done;
      assign val_vec[i]  = stat[i].value;
   end

   aog_pack u_pack (.keep(keep_vec), .vals(val_vec), .rsp(packed_rsp));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (accept) state_in = T_BUSY;
         T_BUSY:  if (capture) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
      // hold the result until taken; load a fresh one on capture
      rsp_valid_in = capture ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         aoa_std_ff   <= 31'd65536;
         tdoa_std_ff  <= 31'd65536;
         thr_ff       <= 32'sd196608;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_AOA_STD:  aoa_std_ff  <= csr_wdata[30:0];
               CSR_TDOA_STD: tdoa_std_ff <= csr_wdata[30:0];
               CSR_THRESH:   thr_ff      <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (capture) rsp_ff <= packed_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AOG_ASSERT_NEXT(a_accept_blocks, clock, reset, accept, req_stall, "beat taken while busy")
   `AOG_ASSERT_NEXT(a_capture_shows, clock, reset, capture, rsp_valid, "captured result not shown")
   `AOG_ASSERT_SAME(a_idle_lanes, clock, reset, state_ff == T_IDLE, !any_done, "lane done while idle")
   `AOG_ASSERT_SAME(a_counts, clock, reset, rsp_valid,
      rsp_data.kept_angles == $countones(rsp_data.valid_mask[2:0]), "angle count off")
endmodule
`default_nettype wire
